/* rtl/smc_kvpc_pkg.sv */
// Package for the key/value port controller: sizes, command and status codes,
// and the key-type response table. No dependencies.

package smc_kvpc_pkg;

	localparam int MAX_KEYS        = 128;
	localparam int MAX_VALUE_BYTES = 32;
	localparam int KEY_AW          = $clog2(MAX_KEYS);
	localparam int VAL_AW          = $clog2(MAX_VALUE_BYTES);
	localparam int LEN_W           = 6;
	localparam int ENTRY_W         = 32 + LEN_W;

	localparam logic [7:0] OPC_READ  = 8'h10;
	localparam logic [7:0] OPC_WRITE = 8'h11;
	localparam logic [7:0] OPC_INDEX = 8'h12;
	localparam logic [7:0] OPC_TYPE  = 8'h13;
	localparam logic [7:0] TYPE_FLAG = 8'hD0;

	localparam logic [3:0] ST_READY = 4'h1;
	localparam logic [3:0] ST_ACK   = 4'h4;
	localparam logic [3:0] ST_NEW   = 4'h8;

	typedef enum logic [2:0] {
		OP_CMD_WR  = 3'd0,
		OP_DATA_WR = 3'd1,
		OP_DATA_RD = 3'd2,
		OP_STAT_RD = 3'd3,
		OP_ERR_RD  = 3'd4,
		OP_ERR_WR  = 3'd5,
		OP_LOAD    = 3'd6,
		OP_NOP     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_INDEX = 3'd3,
		CMD_TYPE  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_INTR      = 2'd1,
		ERR_STILL_BAD = 2'd2,
		ERR_BAD       = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		SRC_BUF  = 2'd0,
		SRC_ZERO = 2'd1,
		SRC_TYPE = 2'd2
	} src_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_COPY  = 5'b00100,
		S_DREAD = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [7:0] v);
		if (v > 8'(MAX_VALUE_BYTES))
			return LEN_W'(MAX_VALUE_BYTES);
		return v[LEN_W-1:0];
	endfunction

	function automatic logic [7:0] type_byte(input logic [LEN_W-1:0] len,
			input logic [LEN_W-1:0] pos);
		logic [31:0] s;
		s = 32'h6368382A;
		case (len)
			LEN_W'(1): s = 32'h75693820;
			LEN_W'(2): s = 32'h75693136;
			LEN_W'(4): s = 32'h75693332;
			default:   s = 32'h6368382A;
		endcase
		case (pos)
			LEN_W'(0): return s[31:24];
			LEN_W'(1): return s[23:16];
			LEN_W'(2): return s[15:8];
			LEN_W'(3): return s[7:0];
			LEN_W'(4): return 8'(len);
			LEN_W'(5): return TYPE_FLAG;
			default:   return 8'h00;
		endcase
	endfunction

endpackage

/* rtl/smc_kvpc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module smc_kvpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/smc_key_value_port_controller.sv */
// Key/value port controller: command, data, status and error ports over one
// transaction channel. Depends on smc_kvpc_pkg and smc_kvpc_ram.
// Most transactions go from S_IDLE to S_EMIT; a data read passes S_DREAD first,
// a key lookup passes S_SCAN, and a value copy after a hit passes S_COPY.
// One transaction at a time: the key scan reads the key RAM once per cycle.
// Reset clears control state and all table slot valid bits; RAMs are not cleared.

module smc_key_value_port_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  value,
	input  logic [6:0]  entry_index,
	input  logic [31:0] entry_key,
	input  logic [5:0]  entry_len,
	input  logic [4:0]  entry_byte_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [1:0]  error_code
);

	import smc_kvpc_pkg::*;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [3:0]         status_q;
	err_t               err_q;
	logic [7:0]         last_byte_q;
	logic [31:0]        key_q;
	logic [2:0]         bpos_q;
	logic [LEN_W-1:0]   rlen_q;
	logic [LEN_W-1:0]   rpos_q;
	src_t               src_q;
	logic [LEN_W-1:0]   type_len_q;
	logic [7:0]         len_byte_q;
	logic [MAX_KEYS-1:0] valid_q;

	logic [KEY_AW-1:0]  scan_addr_q;
	logic               scan_go_q;
	logic               cmp_vld_s1;
	logic [KEY_AW-1:0]  cmp_addr_s1;
	logic [KEY_AW-1:0]  hit_slot_q;
	logic [LEN_W-1:0]   hit_len_q;
	logic [LEN_W-1:0]   copy_rd_q;
	logic               copy_vld_s1;
	logic [VAL_AW-1:0]  copy_pos_s1;

	logic [7:0]         res_data_q;
	logic [1:0]         res_err_q;
	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic [1:0]         out_err_q;

	logic               accept;
	op_t                op;
	logic [ENTRY_W-1:0] kl_rdata;
	logic [7:0]         val_rdata;
	logic [7:0]         buf_rdata;
	logic               kl_we;
	logic               val_we;
	logic               match;
	logic [31:0]        key_next;
	cmd_t               dec_cmd;
	logic [7:0]         rd_byte;
	logic [LEN_W-1:0]   rpos_inc;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign op = op_t'(operation);
	assign kl_we = accept && (op == OP_LOAD) && ({1'b0, entry_index} < 8'(MAX_KEYS));
	assign val_we = kl_we && ({1'b0, entry_byte_index} < 6'(MAX_VALUE_BYTES));
	assign match = cmp_vld_s1 && valid_q[cmp_addr_s1] && (kl_rdata[LEN_W-1:0] != '0)
		&& (kl_rdata[ENTRY_W-1:LEN_W] == key_q);
	assign rpos_inc = rpos_q + LEN_W'(1);

	always_comb begin
		key_next = key_q;
		case (bpos_q[1:0])
			2'd0:    key_next[31:24] = value;
			2'd1:    key_next[23:16] = value;
			2'd2:    key_next[15:8]  = value;
			default: key_next[7:0]   = value;
		endcase
	end

	always_comb begin
		case (value)
			OPC_READ:  dec_cmd = CMD_READ;
			OPC_WRITE: dec_cmd = CMD_WRITE;
			OPC_INDEX: dec_cmd = CMD_INDEX;
			OPC_TYPE:  dec_cmd = CMD_TYPE;
			default:   dec_cmd = CMD_NONE;
		endcase
	end

	always_comb begin
		case (src_q)
			SRC_BUF:  rd_byte = buf_rdata;
			SRC_TYPE: rd_byte = type_byte(type_len_q, rpos_q);
			default:  rd_byte = 8'h00;
		endcase
	end

	smc_kvpc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk   (clk),
		.we    (kl_we),
		.waddr (entry_index[KEY_AW-1:0]),
		.wdata ({entry_key, clamp_len({2'b00, entry_len})}),
		.raddr (scan_addr_q),
		.rdata (kl_rdata)
	);

	smc_kvpc_ram #(.WIDTH(8), .DEPTH(MAX_KEYS * MAX_VALUE_BYTES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr ({entry_index[KEY_AW-1:0], entry_byte_index[VAL_AW-1:0]}),
		.wdata (value),
		.raddr ({hit_slot_q, copy_rd_q[VAL_AW-1:0]}),
		.rdata (val_rdata)
	);

	smc_kvpc_ram #(.WIDTH(8), .DEPTH(MAX_VALUE_BYTES)) u_buf_ram (
		.clk   (clk),
		.we    (copy_vld_s1),
		.waddr (copy_pos_s1),
		.wdata (val_rdata),
		.raddr (rpos_q[VAL_AW-1:0]),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_NONE;
			status_q    <= '0;
			err_q       <= ERR_NONE;
			last_byte_q <= '0;
			key_q       <= '0;
			bpos_q      <= '0;
			rlen_q      <= '0;
			rpos_q      <= '0;
			src_q       <= SRC_ZERO;
			type_len_q  <= '0;
			valid_q     <= '0;
			scan_go_q   <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			copy_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (kl_we)
				valid_q[entry_index[KEY_AW-1:0]] <= 1'b1;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EMIT;
						case (op)
							OP_CMD_WR: begin
								if (dec_cmd == CMD_NONE) begin
									status_q <= ST_NEW;
									err_q    <= ERR_BAD;
								end else if (status_q == 4'h0 || status_q == ST_NEW) begin
									cmd_q    <= dec_cmd;
									status_q <= ST_NEW | ST_ACK;
								end else begin
									status_q <= ST_NEW;
									err_q    <= ERR_INTR;
								end
								bpos_q <= '0;
								rpos_q <= '0;
							end
							OP_DATA_WR: begin
								if (cmd_q == CMD_NONE) begin
									status_q <= '0;
									err_q    <= ERR_STILL_BAD;
								end else if (status_q != 4'h0) begin
									if (bpos_q != 3'd5)
										bpos_q <= bpos_q + 3'd1;
									if (cmd_q == CMD_READ || cmd_q == CMD_WRITE) begin
										if (bpos_q < 3'd4) begin
											key_q    <= key_next;
											status_q <= ST_ACK;
										end else if (bpos_q == 3'd4) begin
											if (cmd_q == CMD_WRITE) begin
												rlen_q   <= clamp_len(value);
												rpos_q   <= '0;
												status_q <= ST_ACK;
											end else begin
												len_byte_q  <= value;
												state_q     <= S_SCAN;
												scan_addr_q <= KEY_AW'(MAX_KEYS - 1);
												scan_go_q   <= 1'b1;
												cmp_vld_s1  <= 1'b0;
											end
										end else if (cmd_q == CMD_WRITE && rpos_q < rlen_q) begin
											rpos_q <= rpos_inc;
											if (rpos_inc == rlen_q) begin
												status_q <= '0;
												err_q    <= ERR_NONE;
											end else begin
												status_q <= ST_ACK;
											end
										end
									end else begin
										if (bpos_q < 3'd3) begin
											key_q    <= key_next;
											status_q <= ST_ACK;
										end else if (bpos_q == 3'd3) begin
											key_q <= key_next;
											if (cmd_q == CMD_INDEX) begin
												src_q    <= SRC_ZERO;
												rlen_q   <= LEN_W'(4);
												rpos_q   <= '0;
												status_q <= ST_ACK | ST_READY;
												err_q    <= ERR_NONE;
											end else begin
												state_q     <= S_SCAN;
												scan_addr_q <= KEY_AW'(MAX_KEYS - 1);
												scan_go_q   <= 1'b1;
												cmp_vld_s1  <= 1'b0;
											end
										end
									end
								end
								res_data_q <= '0;
								res_err_q  <= ERR_NONE;
							end
							OP_DATA_RD: begin
								res_data_q <= last_byte_q;
								res_err_q  <= ERR_NONE;
								if (cmd_q == CMD_READ || cmd_q == CMD_INDEX ||
										cmd_q == CMD_TYPE) begin
									if ((status_q & ST_READY) != 4'h0 && rpos_q < rlen_q)
										state_q <= S_DREAD;
								end else begin
									status_q <= '0;
									err_q    <= ERR_STILL_BAD;
								end
							end
							default: ;
						endcase
						if (op != OP_DATA_WR && op != OP_DATA_RD) begin
							res_data_q <= (op == OP_STAT_RD) ? {4'h0, status_q} : 8'h00;
							res_err_q  <= (op == OP_ERR_RD) ? err_q : ERR_NONE;
						end
					end
				end
				S_SCAN: begin
					cmp_vld_s1  <= scan_go_q;
					cmp_addr_s1 <= scan_addr_q;
					if (scan_go_q) begin
						if (scan_addr_q == '0)
							scan_go_q <= 1'b0;
						else
							scan_addr_q <= scan_addr_q - KEY_AW'(1);
					end
					if (match || (cmp_vld_s1 && cmp_addr_s1 == '0)) begin
						scan_go_q  <= 1'b0;
						cmp_vld_s1 <= 1'b0;
						hit_slot_q <= cmp_addr_s1;
						hit_len_q  <= kl_rdata[LEN_W-1:0];
						copy_rd_q  <= '0;
						if (cmd_q == CMD_TYPE) begin
							src_q      <= SRC_TYPE;
							type_len_q <= match ? kl_rdata[LEN_W-1:0] : LEN_W'(1);
							rlen_q     <= LEN_W'(6);
							rpos_q     <= '0;
							status_q   <= ST_ACK | ST_READY;
							err_q      <= ERR_NONE;
							state_q    <= S_EMIT;
						end else if (match) begin
							state_q <= S_COPY;
						end else begin
							src_q    <= SRC_ZERO;
							rlen_q   <= clamp_len(len_byte_q);
							rpos_q   <= '0;
							status_q <= ST_ACK | ST_READY;
							err_q    <= ERR_NONE;
							state_q  <= S_EMIT;
						end
					end
				end
				S_COPY: begin
					copy_vld_s1 <= (copy_rd_q < hit_len_q);
					copy_pos_s1 <= copy_rd_q[VAL_AW-1:0];
					if (copy_rd_q < hit_len_q)
						copy_rd_q <= copy_rd_q + LEN_W'(1);
					else if (!copy_vld_s1) begin
						src_q    <= SRC_BUF;
						rlen_q   <= hit_len_q;
						rpos_q   <= '0;
						status_q <= ST_ACK | ST_READY;
						err_q    <= ERR_NONE;
						state_q  <= S_EMIT;
					end
				end
				S_DREAD: begin
					last_byte_q <= rd_byte;
					res_data_q  <= rd_byte;
					rpos_q      <= rpos_inc;
					status_q    <= (rpos_inc == rlen_q) ? 4'h0 : (ST_ACK | ST_READY);
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_data_q;
						out_err_q   <= res_err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = out_data_q;
	assign error_code = out_err_q;

endmodule

/* tb/tb_smc_key_value_port_controller.sv */
// Self-checking testbench for smc_key_value_port_controller: table loads,
// command/data port sequences and noise, checked against a built-in predictor.
// Depends on smc_kvpc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_smc_key_value_port_controller;
	import smc_kvpc_pkg::*;

	class kv_scoreboard;
		cmd_t        cur_cmd;
		logic [3:0]  status;
		err_t        err;
		logic [7:0]  last_b;
		logic [31:0] key_nm;
		int          bpos;
		int          rlen;
		int          rpos;
		logic [7:0]  rbuf [MAX_VALUE_BYTES];
		logic [31:0] tkeys [MAX_KEYS];
		int          tlens [MAX_KEYS];
		logic [7:0]  tvals [MAX_KEYS][MAX_VALUE_BYTES];
		logic [7:0]  exp_rd [$];
		logic [1:0]  exp_ec [$];
		int          errors;
		int          checked;

		function new();
			cur_cmd = CMD_NONE;
			status = 4'h0;
			err = ERR_NONE;
			last_b = 8'h00;
			key_nm = 32'h0;
			bpos = 0;
			rlen = 0;
			rpos = 0;
			errors = 0;
			checked = 0;
			for (int i = 0; i < MAX_KEYS; i++)
				tlens[i] = 0;
		endfunction

		function int find_slot();
			for (int i = MAX_KEYS - 1; i >= 0; i--)
				if (tlens[i] != 0 && tkeys[i] == key_nm)
					return i;
			return -1;
		endfunction

		function int clip(int v);
			return (v > MAX_VALUE_BYTES) ? MAX_VALUE_BYTES : v;
		endfunction

		function void put_key_byte(logic [7:0] v);
			int sh;
			sh = (3 - (bpos & 3)) * 8;
			key_nm[sh +: 8] = v;
		endfunction

		function void ready_resp(int len);
			rlen = len;
			rpos = 0;
			status = ST_ACK | ST_READY;
			err = ERR_NONE;
		endfunction

		function void set_type(int n);
			logic [31:0] s;
			case (n)
				1: s = "ui8 ";
				2: s = "ui16";
				4: s = "ui32";
				default: s = "ch8*";
			endcase
			for (int i = 0; i < 4; i++)
				rbuf[i] = s[31 - 8 * i -: 8];
			rbuf[4] = 8'(n);
			rbuf[5] = TYPE_FLAG;
		endfunction

		function void cmd_write(logic [7:0] v);
			cmd_t c;
			case (v)
				OPC_READ:  c = CMD_READ;
				OPC_WRITE: c = CMD_WRITE;
				OPC_INDEX: c = CMD_INDEX;
				OPC_TYPE:  c = CMD_TYPE;
				default:   c = CMD_NONE;
			endcase
			if (c == CMD_NONE) begin
				status = ST_NEW;
				err = ERR_BAD;
			end else if (status == 4'h0 || status == ST_NEW) begin
				cur_cmd = c;
				status = ST_NEW | ST_ACK;
			end else begin
				status = ST_NEW;
				err = ERR_INTR;
			end
			bpos = 0;
			rpos = 0;
		endfunction

		function void data_write(logic [7:0] v);
			int d;
			if (cur_cmd == CMD_NONE) begin
				status = 4'h0;
				err = ERR_STILL_BAD;
				return;
			end
			if (status == 4'h0)
				return;
			if (cur_cmd == CMD_READ || cur_cmd == CMD_WRITE) begin
				if (bpos < 4) begin
					put_key_byte(v);
					status = ST_ACK;
				end else if (bpos == 4) begin
					if (cur_cmd == CMD_WRITE) begin
						rlen = clip(v);
						rpos = 0;
						status = ST_ACK;
					end else begin
						d = find_slot();
						if (d >= 0) begin
							for (int i = 0; i < tlens[d]; i++)
								rbuf[i] = tvals[d][i];
							ready_resp(tlens[d]);
						end else begin
							for (int i = 0; i < MAX_VALUE_BYTES; i++)
								rbuf[i] = 8'h00;
							ready_resp(clip(v));
						end
					end
				end else if (cur_cmd == CMD_WRITE && rpos < rlen) begin
					rbuf[rpos] = v;
					rpos++;
					if (rpos == rlen) begin
						status = 4'h0;
						err = ERR_NONE;
					end else
						status = ST_ACK;
				end
			end else begin
				if (bpos < 3) begin
					put_key_byte(v);
					status = ST_ACK;
				end else if (bpos == 3) begin
					put_key_byte(v);
					if (cur_cmd == CMD_INDEX) begin
						for (int i = 0; i < 4; i++)
							rbuf[i] = 8'h00;
						ready_resp(4);
					end else begin
						d = find_slot();
						set_type(d >= 0 ? tlens[d] : 1);
						ready_resp(6);
					end
				end
			end
			if (bpos < 5)
				bpos++;
		endfunction

		function void data_read();
			if (cur_cmd == CMD_READ || cur_cmd == CMD_INDEX || cur_cmd == CMD_TYPE) begin
				if (!status[0])
					return;
				if (rpos < rlen && rpos < MAX_VALUE_BYTES) begin
					last_b = rbuf[rpos];
					rpos++;
					status = (rpos == rlen) ? 4'h0 : (ST_ACK | ST_READY);
				end
			end else begin
				status = 4'h0;
				err = ERR_STILL_BAD;
			end
		endfunction

		function void note(op_t op, logic [7:0] v, logic [6:0] idx, logic [31:0] k,
				logic [5:0] len, logic [4:0] bidx);
			logic [7:0] rd;
			logic [1:0] ec;
			rd = 8'h00;
			ec = 2'd0;
			case (op)
				OP_CMD_WR:  cmd_write(v);
				OP_DATA_WR: data_write(v);
				OP_DATA_RD: begin
					data_read();
					rd = last_b;
				end
				OP_STAT_RD: rd = {4'h0, status};
				OP_ERR_RD:  ec = err;
				OP_LOAD: begin
					tkeys[idx] = k;
					tlens[idx] = clip(len);
					tvals[idx][bidx] = v;
				end
				default: ;
			endcase
			exp_rd.push_back(rd);
			exp_ec.push_back(ec);
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [7:0] rd, logic [1:0] ec);
			logic [7:0] w_rd;
			logic [1:0] w_ec;
			if (exp_rd.size() == 0) begin
				report($sformatf("unexpected transaction rd=%02h ec=%0d", rd, ec));
				return;
			end
			w_rd = exp_rd.pop_front();
			w_ec = exp_ec.pop_front();
			checked++;
			if (rd !== w_rd)
				report($sformatf("read_data %02h, expected %02h", rd, w_rd));
			if (ec !== w_ec)
				report($sformatf("error_code %0d, expected %0d", ec, w_ec));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  operation;
	logic [7:0]  value;
	logic [6:0]  entry_index;
	logic [31:0] entry_key;
	logic [5:0]  entry_len;
	logic [4:0]  entry_byte_index;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_data;
	logic [1:0]  error_code;

	kv_scoreboard sb;
	logic [31:0]  known_keys [$];
	int           sent;
	int           seqs;
	bit           quiet;

	smc_key_value_port_controller dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .value(value), .entry_index(entry_index),
		.entry_key(entry_key), .entry_len(entry_len),
		.entry_byte_index(entry_byte_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .error_code(error_code)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** smc_key_value_port_controller: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note(op_t'(operation), value, entry_index, entry_key, entry_len,
				entry_byte_index);
		if (arst_n && out_valid && out_ready)
			sb.check(read_data, error_code);
	end

	always @(posedge clk)
		out_ready <= quiet || ($urandom_range(0, 99) >= 24);

	task send(op_t op, logic [7:0] v, logic [6:0] idx, logic [31:0] k,
			logic [5:0] len, logic [4:0] bidx);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(0, 99) < 24 && gap < 6)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		entry_index <= idx;
		entry_key <= k;
		entry_len <= len;
		entry_byte_index <= bidx;
		do @(posedge clk); while (!in_ready);
		sent++;
		quiet = (sent >= 300 && sent < 400);
	endtask

	task port(op_t op, logic [7:0] v);
		send(op, v, 7'($urandom), $urandom, 6'($urandom), 5'($urandom));
	endtask

	task load_entry(int slot, logic [31:0] k, int len);
		known_keys.push_back(k);
		if (len == 0)
			send(OP_LOAD, 8'($urandom), 7'(slot), k, 6'd0, 5'($urandom_range(0, 31)));
		else
			for (int b = 0; b < len; b++)
				send(OP_LOAD, 8'($urandom), 7'(slot), k, 6'(len), 5'(b));
	endtask

	task poke_status();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			port(OP_STAT_RD, 8'($urandom));
		else if (r < 14)
			port(OP_ERR_RD, 8'($urandom));
	endtask

	task run_sequence(logic [7:0] opc, logic [31:0] k, logic [7:0] len_byte, int n);
		if (sb.status != 4'h0 && sb.status != ST_NEW)
			port(OP_CMD_WR, 8'hFF);
		port(OP_CMD_WR, opc);
		for (int i = 0; i < 4; i++) begin
			port(OP_DATA_WR, k[31 - 8 * i -: 8]);
			poke_status();
		end
		if (opc == OPC_READ || opc == OPC_WRITE)
			port(OP_DATA_WR, len_byte);
		for (int i = 0; i < n; i++) begin
			port(opc == OPC_WRITE ? OP_DATA_WR : OP_DATA_RD, 8'($urandom));
			poke_status();
		end
		port(OP_STAT_RD, 8'h00);
		port(OP_ERR_RD, 8'h00);
		seqs++;
	endtask

	function logic [31:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 99) < 75)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return $urandom;
	endfunction

	function int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return MAX_VALUE_BYTES;
		if (r < 18)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	initial begin
		logic [7:0] opc;
		int         r;
		int         n;
		sb = new();
		sent = 0;
		seqs = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		operation = OP_NOP;
		value = 8'h00;
		entry_index = 7'd0;
		entry_key = 32'h0;
		entry_len = 6'd0;
		entry_byte_index = 5'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		port(OP_ERR_RD, 8'h00);
		port(OP_NOP, 8'hFF);
		port(OP_ERR_WR, 8'hFF);
		port(OP_DATA_RD, 8'h00);
		port(OP_ERR_RD, 8'h00);
		port(OP_DATA_WR, 8'hFF);
		port(OP_CMD_WR, 8'h00);
		port(OP_ERR_RD, 8'h00);
		load_entry(0, 32'h0, 1);
		load_entry(5, 32'hFFFFFFFF, 4);
		load_entry(127, 32'hFFFFFFFF, 2);
		load_entry(64, 32'h12345678, 0);
		run_sequence(OPC_READ, 32'hFFFFFFFF, 8'h00, 3);
		run_sequence(OPC_TYPE, 32'hFFFFFFFF, 8'h00, 6);
		run_sequence(OPC_INDEX, 32'h0, 8'h00, 5);
		run_sequence(OPC_READ, 32'hDEADBEEF, 8'hFF, 33);
		run_sequence(OPC_TYPE, 32'h12345678, 8'h00, 7);
		run_sequence(OPC_WRITE, 32'h0, 8'hFF, 34);
		port(OP_DATA_WR, 8'h55);
		port(OP_DATA_RD, 8'h00);
		port(OP_CMD_WR, OPC_READ);
		port(OP_CMD_WR, OPC_TYPE);
		port(OP_ERR_RD, 8'h00);

		load_entry(127, 32'hA5A5A5A5, MAX_VALUE_BYTES);
		while (sent < 620) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				case ($urandom_range(0, 3))
					0: opc = OPC_READ;
					1: opc = OPC_WRITE;
					2: opc = OPC_INDEX;
					default: opc = OPC_TYPE;
				endcase
				n = ($urandom_range(0, 99) < 12) ? $urandom_range(30, 36)
					: $urandom_range(0, 8);
				run_sequence(opc, pick_key(),
					($urandom_range(0, 99) < 15) ? 8'($urandom) : 8'($urandom_range(0, 8)),
					n);
			end else if (r < 80)
				load_entry($urandom_range(0, MAX_KEYS - 1),
					($urandom_range(0, 99) < 30) ? pick_key() : $urandom, pick_len());
			else if (r < 88)
				port(OP_CMD_WR, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h10, 8'h13))
					: 8'($urandom));
			else
				port(op_t'($urandom_range(1, 7) == 6 ? 7 : $urandom_range(1, 5)), 8'($urandom));
		end
		in_valid <= 1'b0;

		while (sb.exp_rd.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d transactions, %0d command sequences, %0d results checked",
			sent, seqs, sb.checked);
		$display("table slots 0..%0d loaded with up to %0d-byte values", MAX_KEYS - 1,
			MAX_VALUE_BYTES);
		if (sb.errors == 0)
			$display("** smc_key_value_port_controller: PASSED **");
		else
			$display("** smc_key_value_port_controller: FAILED **");
		$finish;
	end

endmodule
